>>> rtl/edc_pkg.sv
package edc_pkg;

    localparam int NUM_FLOORS = 8;
    localparam int FLOOR_W = 3;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 16;

    typedef logic [NUM_FLOORS-1:0] t_floor_mask;
    typedef logic [FLOOR_W-1:0] t_floor;

    typedef enum logic [1:0] {
        HEAD_STOP = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_heading;

    localparam t_floor TOP_FLOOR = t_floor'(NUM_FLOORS - 1);

    typedef struct packed {
        t_floor      floor_pos;
        t_heading    heading;
        t_floor_mask stops;
    } t_car_state;

    typedef struct packed {
        t_floor_mask inside_calls;
        t_floor_mask hall_up_calls;
        t_floor_mask hall_down_calls;
    } t_calls;

endpackage

>>> rtl/edc_decide.sv
module edc_decide (
    input  edc_pkg::t_car_state i_state,
    input  edc_pkg::t_calls     i_calls,
    output edc_pkg::t_car_state o_state,
    output logic                o_door_cycled
);

    edc_pkg::t_floor_mask here;
    edc_pkg::t_floor_mask below;
    edc_pkg::t_floor_mask above;
    edc_pkg::t_floor_mask top_down_call;
    edc_pkg::t_floor_mask stops;
    edc_pkg::t_heading    heading;
    logic                 at_base;
    logic                 at_top;

    assign here  = edc_pkg::t_floor_mask'(1) << i_state.floor_pos;
    assign below = here - edc_pkg::t_floor_mask'(1);
    assign above = ~(below | here);
    assign at_base = (i_state.floor_pos == '0);
    assign at_top  = (i_state.floor_pos == edc_pkg::TOP_FLOOR);

    always_comb begin
        top_down_call = '0;
        for (int i = 0; i < edc_pkg::NUM_FLOORS; i++) begin
            if (i_calls.hall_down_calls[i]) begin
                top_down_call = edc_pkg::t_floor_mask'(1) << i;
            end
        end
    end

    always_comb begin
        stops = i_state.stops;
        heading = i_state.heading;
        o_door_cycled = 1'b0;

        if (at_base && (i_calls.hall_up_calls[0] || i_calls.hall_down_calls[0])) begin
            stops[0] = 1'b1;
        end
        stops = stops | i_calls.inside_calls;

        if ((stops & here) != '0) begin
            o_door_cycled = 1'b1;
            heading = edc_pkg::HEAD_STOP;
            stops = stops & ~here;
        end else if (at_base && i_state.heading == edc_pkg::HEAD_DOWN) begin
            heading = edc_pkg::HEAD_STOP;
        end else if (i_state.heading == edc_pkg::HEAD_UP || at_base) begin
            stops = stops | top_down_call | (i_calls.hall_up_calls & ~below);
            if ((stops & above) != '0) begin
                heading = edc_pkg::HEAD_UP;
            end
        end else if (i_state.heading == edc_pkg::HEAD_DOWN || at_top) begin
            stops = stops | (i_calls.hall_down_calls & (below | here));
            if ((stops & below) != '0) begin
                heading = edc_pkg::HEAD_DOWN;
            end
        end else begin
            if ((stops & above) != '0) begin
                heading = edc_pkg::HEAD_UP;
            end else begin
                heading = edc_pkg::HEAD_DOWN;
            end
        end

        o_state.stops = stops;
        o_state.heading = heading;
        o_state.floor_pos = i_state.floor_pos;
        case (heading)
            edc_pkg::HEAD_UP: begin
                if (!at_top) begin
                    o_state.floor_pos = i_state.floor_pos + edc_pkg::t_floor'(1);
                end
            end
            edc_pkg::HEAD_DOWN: begin
                if (!at_base) begin
                    o_state.floor_pos = i_state.floor_pos - edc_pkg::t_floor'(1);
                end
            end
            default: begin
                o_state.floor_pos = i_state.floor_pos;
            end
        endcase
    end

endmodule

>>> rtl/elevator_direction_controller_core.sv
// Elevator direction controller. Each input transfer carries the inside car
// calls and the hall up and down calls as floor bitmasks, and produces exactly
// one output transfer with the car floor after the move, the chosen heading,
// whether the door cycled, and the stops still pending. The block takes one
// transfer every clock cycle while the output is not back-pressured. A result
// passes through the input register, which feeds the decision logic, which
// updates the car state and loads the output register when the output can
// advance. Back-pressure on the output stalls both stages. After reset the car
// is at the basement, stopped, with no pending stops.
module elevator_direction_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // inside_calls[7:0], hall_up_calls[15:8], hall_down_calls[23:16]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // floor_now[2:0], heading[4:3], door_cycled[5], pending_stops[13:6], zero[15:14]
    output logic [15:0] m_axis_tdata
);

    logic                 r_in_valid;
    logic                 n_in_valid;
    edc_pkg::t_calls      r_calls;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [15:0]          r_out_data;
    edc_pkg::t_car_state  r_state;
    edc_pkg::t_car_state  n_state;
    logic                 door_cycled;
    logic                 advance;
    edc_pkg::t_calls      in_calls;

    assign in_calls.inside_calls    = s_axis_tdata[7:0];
    assign in_calls.hall_up_calls   = s_axis_tdata[15:8];
    assign in_calls.hall_down_calls = s_axis_tdata[23:16];

    assign advance = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    edc_decide u_decide (
        .i_state       (r_state),
        .i_calls       (r_calls),
        .o_state       (n_state),
        .o_door_cycled (door_cycled)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.floor_pos <= '0;
            r_state.heading <= edc_pkg::HEAD_STOP;
            r_state.stops <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (r_in_valid && advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_calls <= in_calls;
        end
        if (r_in_valid && advance) begin
            r_out_data <= {2'b00, n_state.stops, door_cycled,
                           n_state.heading, n_state.floor_pos};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;

endmodule
